// File: src/stable_sorted_insert_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted insert queue
// Shared concurrent assertion forms with clock and active-low reset.
// ----------------------------------------------------------------------------
`ifndef STABLE_SORTED_INSERT_QUEUE_ASSERT_SVH
`define STABLE_SORTED_INSERT_QUEUE_ASSERT_SVH

// same-cycle implication
`define SSIQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSIQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ssiq_pkg.sv
// ----------------------------------------------------------------------------
// ssiq_pkg
// Shared constants and types of the stable sorted insert queue.
// ----------------------------------------------------------------------------
package ssiq_pkg;

    // default sizes
    localparam int DEPTH_DEF        = 16;
    localparam int KEY_BITS_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 16;

    // operation codes
    localparam logic [1:0] OP_APPEND  = 2'd0;
    localparam logic [1:0] OP_ORDERED = 2'd1;
    localparam logic [1:0] OP_POP     = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // item accepted: evaluate compares, latch request
        logic apply;    // shift cells and update count
        logic load;     // load result register from the updated queue
    } ssiq_cmd_t;

endpackage

// File: src/ssiq_ctrl.sv
// ----------------------------------------------------------------------------
// ssiq_ctrl
// Sequencer of the queue: accept, apply, result load, output valid.
// ----------------------------------------------------------------------------
module ssiq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output ssiq_pkg::ssiq_cmd_t cmd
);
    import ssiq_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_APPLY = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;
    logic       in_acc;

    // output slot can take a new result
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;

    // commands
    always_comb begin
        cmd.capture = in_acc;
        cmd.apply   = (state_reg == ST_APPLY);
        cmd.load    = (state_reg == ST_DONE) && out_free;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) state_next = ST_APPLY;
            end
            ST_APPLY: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = in_acc ? ST_APPLY : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid
    always_comb begin
        if (cmd.load)      m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
        else               m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: src/ssiq_datapath.sv
// ----------------------------------------------------------------------------
// ssiq_datapath
// Row of key/payload cells with per-cell compares, shift insert and pop,
// count, tail copy and result register.
// ----------------------------------------------------------------------------
module ssiq_datapath #(
    parameter int DEPTH        = ssiq_pkg::DEPTH_DEF,
    parameter int KEY_BITS     = ssiq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = ssiq_pkg::PAYLOAD_BITS_DEF,
    parameter int CNT_W        = $clog2(DEPTH + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ssiq_pkg::ssiq_cmd_t     cmd,
    input  logic                    cfg_wr_en,
    input  logic                    cfg_wr_data,
    input  logic [1:0]              in_operation,
    input  logic [KEY_BITS-1:0]     in_key,
    input  logic [PAYLOAD_BITS-1:0] in_payload,
    output logic                    out_accepted,
    output logic [KEY_BITS-1:0]     out_popped_key,
    output logic [PAYLOAD_BITS-1:0] out_popped_payload,
    output logic [CNT_W-1:0]        out_entry_count,
    output logic                    out_is_empty,
    output logic [KEY_BITS-1:0]     out_head_key,
    output logic [PAYLOAD_BITS-1:0] out_head_payload,
    output logic [KEY_BITS-1:0]     out_tail_key,
    output logic [PAYLOAD_BITS-1:0] out_tail_payload
);
    import ssiq_pkg::*;

    localparam int LOG_D = $clog2(DEPTH);

    // cells, slot 0 is the head
    logic [KEY_BITS-1:0]     key_reg  [DEPTH];
    logic [PAYLOAD_BITS-1:0] pay_reg  [DEPTH];
    logic [KEY_BITS-1:0]     key_next [DEPTH];
    logic [PAYLOAD_BITS-1:0] pay_next [DEPTH];
    logic [KEY_BITS-1:0]     up_key   [DEPTH];
    logic [PAYLOAD_BITS-1:0] up_pay   [DEPTH];
    logic [KEY_BITS-1:0]     dn_key   [DEPTH];
    logic [PAYLOAD_BITS-1:0] dn_pay   [DEPTH];

    logic                    cmp_en_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [KEY_BITS-1:0]     tail_key_reg;
    logic [PAYLOAD_BITS-1:0] tail_pay_reg;

    // latched request
    logic [DEPTH-1:0]        hit_reg;
    logic                    ins_reg, pop_reg, ok_reg, tail_new_reg;
    logic [KEY_BITS-1:0]     new_key_reg, pop_key_reg;
    logic [PAYLOAD_BITS-1:0] new_pay_reg, pop_pay_reg;

    // result register
    logic                    res_acc_reg;
    logic [KEY_BITS-1:0]     res_pk_reg, res_hk_reg, res_tk_reg;
    logic [PAYLOAD_BITS-1:0] res_pp_reg, res_hp_reg, res_tp_reg;
    logic [CNT_W-1:0]        res_cnt_reg;

    logic [DEPTH-1:0]        hit, occ_mask, pre, shift_mask, at;
    logic                    full, empty, is_ins, is_pop, ordered;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign is_ins  = (in_operation == OP_APPEND) || (in_operation == OP_ORDERED);
    assign is_pop  = (in_operation == OP_POP);
    assign ordered = (in_operation == OP_ORDERED) && cmp_en_reg;

    // per-cell placement candidates: before the head, between two keys, or at the tail
    always_comb begin
        for (int j = 0; j < DEPTH; j++) begin
            occ_mask[j] = (CNT_W'(j) < count_reg);
            if (j == 0) begin
                hit[j] = ordered && occ_mask[j] && (in_key < key_reg[0]);
            end else begin
                hit[j] = ordered && occ_mask[j] &&
                         (in_key >= key_reg[(j > 0) ? j - 1 : 0]) && (in_key < key_reg[j]);
            end
            if (CNT_W'(j) == count_reg) hit[j] = 1'b1;
        end
    end

    // first candidate wins: prefix OR in log steps
    always_comb begin
        pre = hit_reg;
        for (int s = 0; s < LOG_D; s++) begin
            pre = pre | (pre << (1 << s));
        end
        shift_mask = pre << 1;
        at         = hit_reg & ~shift_mask;
    end

    // neighbor taps of each cell
    for (genvar g = 0; g < DEPTH; g++) begin : g_tap
        if (g == 0) begin : g_first
            assign up_key[g] = key_reg[g];
            assign up_pay[g] = pay_reg[g];
        end else begin : g_mid
            assign up_key[g] = key_reg[g-1];
            assign up_pay[g] = pay_reg[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign dn_key[g] = key_reg[g];
            assign dn_pay[g] = pay_reg[g];
        end else begin : g_inner
            assign dn_key[g] = key_reg[g+1];
            assign dn_pay[g] = pay_reg[g+1];
        end
    end

    // cell next values
    always_comb begin
        for (int j = 0; j < DEPTH; j++) begin
            key_next[j] = key_reg[j];
            pay_next[j] = pay_reg[j];
            if (cmd.apply && ins_reg) begin
                if (shift_mask[j]) begin
                    key_next[j] = up_key[j];
                    pay_next[j] = up_pay[j];
                end else if (at[j]) begin
                    key_next[j] = new_key_reg;
                    pay_next[j] = new_pay_reg;
                end
            end else if (cmd.apply && pop_reg) begin
                key_next[j] = dn_key[j];
                pay_next[j] = dn_pay[j];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.apply && ins_reg)      count_next = count_reg + CNT_W'(1);
        else if (cmd.apply && pop_reg) count_next = count_reg - CNT_W'(1);
    end

    // cells and tail copy
    always_ff @(posedge aclk) begin
        for (int j = 0; j < DEPTH; j++) begin
            key_reg[j] <= key_next[j];
            pay_reg[j] <= pay_next[j];
        end
        if (cmd.apply && ins_reg && tail_new_reg) begin
            tail_key_reg <= new_key_reg;
            tail_pay_reg <= new_pay_reg;
        end
    end

    // control state: count and compare enable
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            cmp_en_reg <= 1'b1;
        end else begin
            count_reg <= count_next;
            if (cfg_wr_en) cmp_en_reg <= cfg_wr_data;
        end
    end

    // request latch on accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ins_reg <= 1'b0;
            pop_reg <= 1'b0;
        end else if (cmd.capture) begin
            ins_reg <= is_ins && !full;
            pop_reg <= is_pop && !empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            hit_reg      <= hit;
            tail_new_reg <= !(|(hit & occ_mask));
            new_key_reg  <= in_key;
            new_pay_reg  <= in_payload;
            ok_reg       <= is_ins ? !full : (is_pop ? !empty : 1'b1);
            pop_key_reg  <= (is_pop && !empty) ? key_reg[0] : '0;
            pop_pay_reg  <= (is_pop && !empty) ? pay_reg[0] : '0;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            res_acc_reg <= ok_reg;
            res_pk_reg  <= pop_key_reg;
            res_pp_reg  <= pop_pay_reg;
            res_cnt_reg <= count_reg;
            res_hk_reg  <= empty ? '0 : key_reg[0];
            res_hp_reg  <= empty ? '0 : pay_reg[0];
            res_tk_reg  <= empty ? '0 : tail_key_reg;
            res_tp_reg  <= empty ? '0 : tail_pay_reg;
        end
    end

    assign out_accepted       = res_acc_reg;
    assign out_popped_key     = res_pk_reg;
    assign out_popped_payload = res_pp_reg;
    assign out_entry_count    = res_cnt_reg;
    assign out_is_empty       = (res_cnt_reg == '0);
    assign out_head_key       = res_hk_reg;
    assign out_head_payload   = res_hp_reg;
    assign out_tail_key       = res_tk_reg;
    assign out_tail_payload   = res_tp_reg;

endmodule

// File: src/stable_sorted_insert_queue.sv
// ----------------------------------------------------------------------------
// stable_sorted_insert_queue
// Bounded queue with append, stable ordered insert, pop and query.
//
//   channel  | direction | contents
//   s_*      | in        | operation, entry_key, entry_payload
//   m_*      | out       | accepted, popped entry, count, empty, head, tail
//   cfg_*    | in        | compare_enabled
//
// Each item is taken in the accepting cycle, which latches the parallel key
// compares of all cells; the apply state then shifts the cell row, and the
// result register loads in the done state, together with the next item.
// Reset empties the queue and sets compare_enabled; cell contents stay as is.
// A stalled m_ side holds the result and the next item's completion.
// ----------------------------------------------------------------------------
module stable_sorted_insert_queue #(
    parameter int DEPTH        = ssiq_pkg::DEPTH_DEF,
    parameter int KEY_BITS     = ssiq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = ssiq_pkg::PAYLOAD_BITS_DEF,
    parameter int CNT_W        = $clog2(DEPTH + 1),
    parameter int IN_W         = ((2 + KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
    parameter int OUT_W        = ((3 + CNT_W + 3 * KEY_BITS + 3 * PAYLOAD_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,     // compare_enabled
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,         // operation, entry_key, entry_payload
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata          // accepted, popped_key, popped_payload,
                                              // entry_count, is_empty, head_key,
                                              // head_payload, tail_key, tail_payload
);
    import ssiq_pkg::*;

    ssiq_cmd_t               cmd;
    logic                    acc, emp;
    logic [KEY_BITS-1:0]     pk, hk, tk;
    logic [PAYLOAD_BITS-1:0] pp, hp, tp;
    logic [CNT_W-1:0]        cnt;

    ssiq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ssiq_datapath #(
        .DEPTH        (DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .CNT_W        (CNT_W)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_operation       (s_tdata[1:0]),
        .in_key             (s_tdata[KEY_BITS+1:2]),
        .in_payload         (s_tdata[KEY_BITS+PAYLOAD_BITS+1:KEY_BITS+2]),
        .out_accepted       (acc),
        .out_popped_key     (pk),
        .out_popped_payload (pp),
        .out_entry_count    (cnt),
        .out_is_empty       (emp),
        .out_head_key       (hk),
        .out_head_payload   (hp),
        .out_tail_key       (tk),
        .out_tail_payload   (tp)
    );

    // pack result, first field lowest
    assign m_tdata = OUT_W'({tp, tk, hp, hk, emp, cnt, pp, pk, acc});

endmodule

// File: src/ssiq_checker.sv
// ----------------------------------------------------------------------------
// ssiq_checker
// Port-level checks on the result channel of the sorted insert queue.
// ----------------------------------------------------------------------------
`include "stable_sorted_insert_queue_assert.svh"

module ssiq_checker #(
    parameter int DEPTH        = ssiq_pkg::DEPTH_DEF,
    parameter int KEY_BITS     = ssiq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = ssiq_pkg::PAYLOAD_BITS_DEF,
    parameter int CNT_W        = $clog2(DEPTH + 1),
    parameter int OUT_W        = ((3 + CNT_W + 3 * KEY_BITS + 3 * PAYLOAD_BITS + 7) / 8) * 8
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);
    localparam int OFF_PK  = 1;
    localparam int OFF_PP  = OFF_PK + KEY_BITS;
    localparam int OFF_CNT = OFF_PP + PAYLOAD_BITS;
    localparam int OFF_EMP = OFF_CNT + CNT_W;
    localparam int OFF_HK  = OFF_EMP + 1;
    localparam int OFF_HP  = OFF_HK + KEY_BITS;
    localparam int OFF_TK  = OFF_HP + PAYLOAD_BITS;
    localparam int OFF_TP  = OFF_TK + KEY_BITS;

    logic                    acc, emp;
    logic [CNT_W-1:0]        cnt;
    logic [KEY_BITS-1:0]     pk, hk, tk;
    logic [PAYLOAD_BITS-1:0] pp, hp, tp;

    assign acc = m_tdata[0];
    assign pk  = m_tdata[OFF_PK +: KEY_BITS];
    assign pp  = m_tdata[OFF_PP +: PAYLOAD_BITS];
    assign cnt = m_tdata[OFF_CNT +: CNT_W];
    assign emp = m_tdata[OFF_EMP];
    assign hk  = m_tdata[OFF_HK +: KEY_BITS];
    assign hp  = m_tdata[OFF_HP +: PAYLOAD_BITS];
    assign tk  = m_tdata[OFF_TK +: KEY_BITS];
    assign tp  = m_tdata[OFF_TP +: PAYLOAD_BITS];

    // stalled result holds
    `SSIQ_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // empty flag agrees with the count
    `SSIQ_ASSERT_NOW(a_empty, aclk, aresetn, m_tvalid, emp == (cnt == '0), "empty flag and count disagree")

    // count never passes capacity
    `SSIQ_ASSERT_NOW(a_cap, aclk, aresetn, m_tvalid, cnt <= CNT_W'(DEPTH), "count above capacity")

    // empty queue shows zero head and tail
    `SSIQ_ASSERT_NOW(a_zero, aclk, aresetn, m_tvalid && emp, (hk == '0) && (hp == '0) && (tk == '0) && (tp == '0), "empty queue shows entries")

    // refused operation pops nothing
    `SSIQ_ASSERT_NOW(a_refuse, aclk, aresetn, m_tvalid && !acc, (pk == '0) && (pp == '0), "refused operation shows popped entry")

endmodule

bind stable_sorted_insert_queue ssiq_checker #(
    .DEPTH        (DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .CNT_W        (CNT_W),
    .OUT_W        (OUT_W)
) u_ssiq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the stable sorted insert queue
// Drives operation items into the s_ stream and checks each result item on the
// m_ stream against a cycle-free model of the queue kept in the bench. Both
// sides idle at random; one phase holds the result side off long enough to
// stall the input. The compare_enabled register is switched between phases.
// ----------------------------------------------------------------------------
module tb;
    import ssiq_pkg::*;

    localparam int QDEPTH       = 16;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_GAP      = 16;

    // input item, first field in the low bits
    typedef struct packed {
        logic [15:0] payload;
        logic [15:0] key;
        logic [1:0]  op;
    } queue_item_t;

    // result item, first field in the low bits
    typedef struct packed {
        logic [15:0] tail_payload;
        logic [15:0] tail_key;
        logic [15:0] head_payload;
        logic [15:0] head_key;
        logic        is_empty;
        logic [4:0]  entry_count;
        logic [15:0] popped_payload;
        logic [15:0] popped_key;
        logic        accepted;
    } queue_status_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic         cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [39:0]  s_tdata;      // operation, entry_key, entry_payload
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;      // accepted, popped_key, popped_payload, entry_count,
                                // is_empty, head_key, head_payload, tail_key,
                                // tail_payload

    // model of the queue contents, slot 0 is the head
    logic [15:0]   held_key [QDEPTH];
    logic [15:0]   held_pay [QDEPTH];
    int            held_count;
    bit            compare_mode;
    queue_status_t expected_status [$];

    int  errors;
    int  items_sent;
    int  results_seen;
    int  op_count [4];
    int  refused_full;
    int  refused_empty;
    int  peak_count;
    bit  tx_idle;
    bit  rx_idle;
    int  hold_len;

    stable_sorted_insert_queue u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #1 aclk = ~aclk;

    // slot that an ordered insert lands in
    function automatic int ordered_slot(logic [15:0] k);
        int i;
        if (held_count == 0) return 0;
        if (k < held_key[0]) return 0;
        for (i = 0; i + 1 < held_count; i++) begin
            if (k >= held_key[i] && k < held_key[i + 1]) return i + 1;
        end
        return held_count;
    endfunction

    // apply one item to the model, return the status it should report
    function automatic queue_status_t apply_item(queue_item_t it);
        queue_status_t st;
        int slot;
        int i;
        st = '0;
        st.accepted = 1'b1;
        case (it.op)
            OP_APPEND, OP_ORDERED: begin
                if (held_count >= QDEPTH) begin
                    st.accepted = 1'b0;
                    refused_full++;
                end else begin
                    slot = held_count;
                    if (it.op == OP_ORDERED && compare_mode) slot = ordered_slot(it.key);
                    for (i = held_count; i > slot; i--) begin
                        held_key[i] = held_key[i - 1];
                        held_pay[i] = held_pay[i - 1];
                    end
                    held_key[slot] = it.key;
                    held_pay[slot] = it.payload;
                    held_count++;
                end
            end
            OP_POP: begin
                if (held_count == 0) begin
                    st.accepted = 1'b0;
                    refused_empty++;
                end else begin
                    st.popped_key     = held_key[0];
                    st.popped_payload = held_pay[0];
                    for (i = 0; i + 1 < held_count; i++) begin
                        held_key[i] = held_key[i + 1];
                        held_pay[i] = held_pay[i + 1];
                    end
                    held_count--;
                end
            end
            default: ;
        endcase
        st.entry_count = held_count[4:0];
        st.is_empty    = (held_count == 0);
        if (held_count > 0) begin
            st.head_key     = held_key[0];
            st.head_payload = held_pay[0];
            st.tail_key     = held_key[held_count - 1];
            st.tail_payload = held_pay[held_count - 1];
        end
        return st;
    endfunction

    function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: mismatch in %s, expected %h, got %h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // monitor: check results, then predict from the item taken at this edge
    always @(posedge aclk) begin
        queue_status_t got;
        queue_status_t exp_st;
        queue_item_t   it;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = queue_status_t'(m_tdata[102:0]);
                results_seen++;
                if (expected_status.size() == 0) begin
                    $display("%0t: result item with nothing expected, got %h", $time, got);
                    errors++;
                end else begin
                    exp_st = expected_status.pop_front();
                    check_field("accepted", exp_st.accepted, got.accepted);
                    check_field("popped_key", exp_st.popped_key, got.popped_key);
                    check_field("popped_payload", exp_st.popped_payload, got.popped_payload);
                    check_field("entry_count", exp_st.entry_count, got.entry_count);
                    check_field("is_empty", exp_st.is_empty, got.is_empty);
                    check_field("head_key", exp_st.head_key, got.head_key);
                    check_field("head_payload", exp_st.head_payload, got.head_payload);
                    check_field("tail_key", exp_st.tail_key, got.tail_key);
                    check_field("tail_payload", exp_st.tail_payload, got.tail_payload);
                end
            end
            if (s_tvalid && s_tready) begin
                it = queue_item_t'(s_tdata[33:0]);
                op_count[it.op]++;
                items_sent++;
                expected_status.push_back(apply_item(it));
                if (held_count > peak_count) peak_count = held_count;
            end
        end
    end

    // result side: random stalls, or one long hold when asked
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_len > 0) begin
                stall    = hold_len;
                hold_len = 0;
            end else begin
                stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    // send one item; returns at the edge where it is taken
    task automatic send_item(logic [1:0] op, logic [15:0] key, logic [15:0] payload);
        int gap;
        queue_item_t it;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        it.op      = op;
        it.key     = key;
        it.payload = payload;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, it};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering, wait for every result and the block to settle
    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_compare_mode(bit mode);
        wait_drain();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        compare_mode = mode;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // keys: small range for many ties, extremes, or anything
    function automatic logic [15:0] random_key();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 7));
            1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // bias 0 fills, 1 drains, 2 balances
    function automatic logic [1:0] random_op(int bias);
        int r;
        r = $urandom_range(0, 99);
        case (bias)
            0: begin
                if (r < 45) return OP_ORDERED;
                if (r < 70) return OP_APPEND;
                if (r < 90) return OP_POP;
                return OP_QUERY;
            end
            1: begin
                if (r < 25) return OP_ORDERED;
                if (r < 35) return OP_APPEND;
                if (r < 85) return OP_POP;
                return OP_QUERY;
            end
            default: begin
                if (r < 35) return OP_ORDERED;
                if (r < 50) return OP_APPEND;
                if (r < 90) return OP_POP;
                return OP_QUERY;
            end
        endcase
    endfunction

    // empty queue cases, ordered placement, ties, unsorted contents
    task automatic test_directed();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_item(OP_POP,     16'h0000, 16'h0000);
        send_item(OP_QUERY,   16'hFFFF, 16'hFFFF);
        send_item(OP_ORDERED, 16'h8000, 16'h1111);
        send_item(OP_ORDERED, 16'h0000, 16'h2222);
        send_item(OP_ORDERED, 16'h0000, 16'h3333);
        send_item(OP_ORDERED, 16'hFFFF, 16'hFFFF);
        send_item(OP_ORDERED, 16'h8000, 16'h4444);
        send_item(OP_ORDERED, 16'hFFFF, 16'h0000);
        send_item(OP_APPEND,  16'h0001, 16'h5555);
        send_item(OP_ORDERED, 16'h0002, 16'h6666);
        send_item(OP_ORDERED, 16'h7FFF, 16'hAAAA);
        send_item(OP_QUERY,   16'h0000, 16'h0000);
        send_item(OP_POP,     16'h1234, 16'h5678);
        send_item(OP_POP,     16'h0000, 16'h0000);
        send_item(OP_APPEND,  16'h0000, 16'hFFFF);
        send_item(OP_ORDERED, 16'h0000, 16'h0001);
        send_item(OP_QUERY,   16'hA5A5, 16'h5A5A);
        send_item(OP_POP,     16'h0000, 16'h0000);
        wait_drain();
    endtask

    // fill past full, then empty past empty
    task automatic test_capacity();
        int i;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (i = 0; i < QDEPTH + 4; i++) send_item(OP_ORDERED, random_key(), 16'($urandom));
        send_item(OP_APPEND,  16'hFFFF, 16'hFFFF);
        send_item(OP_ORDERED, 16'h0000, 16'h0000);
        send_item(OP_QUERY,   16'h0000, 16'h0000);
        for (i = 0; i < QDEPTH + 4; i++) send_item(OP_POP, 16'h0000, 16'h0000);
        send_item(OP_QUERY,   16'hFFFF, 16'hFFFF);
        wait_drain();
    endtask

    // ordered insert appends while comparing is off
    task automatic test_compare_off();
        int i;
        set_compare_mode(1'b0);
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        for (i = 0; i < 12; i++) send_item(OP_ORDERED, 16'(QDEPTH - i), 16'(i));
        for (i = 0; i < 14; i++) send_item(OP_POP, 16'h0000, 16'h0000);
        set_compare_mode(1'b1);
    endtask

    // long hold on the result side while items keep coming
    task automatic test_backpressure();
        int i;
        tx_idle  = 1'b0;
        rx_idle  = 1'b0;
        hold_len = 120;
        for (i = 0; i < 40; i++) send_item(random_op(0), random_key(), 16'($urandom));
        rx_idle = 1'b1;
        for (i = 0; i < 20; i++) send_item(random_op(1), random_key(), 16'($urandom));
        wait_drain();
    endtask

    // segments of random traffic that drift between full and empty
    task automatic test_random_traffic(int n_items);
        int i;
        int bias;
        for (i = 0; i < n_items; i++) begin
            if (i % 40 == 0) begin
                bias = $urandom_range(0, 2);
                if ($urandom_range(0, 3) == 0) begin
                    tx_idle = 1'b0;
                    rx_idle = 1'b0;
                end else begin
                    tx_idle = $urandom_range(0, 1);
                    rx_idle = $urandom_range(0, 1);
                end
            end
            send_item(random_op(bias), random_key(), 16'($urandom));
        end
    endtask

    initial begin : run_tests
        aclk          = 1'b0;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        held_count    = 0;
        compare_mode  = 1'b1;
        errors        = 0;
        items_sent    = 0;
        results_seen  = 0;
        refused_full  = 0;
        refused_empty = 0;
        peak_count    = 0;
        op_count      = '{0, 0, 0, 0};
        tx_idle       = 1'b0;
        rx_idle       = 1'b0;
        hold_len      = 0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_capacity();
        test_compare_off();
        test_backpressure();
        test_random_traffic(350);
        set_compare_mode(1'b0);
        test_random_traffic(200);
        set_compare_mode(1'b1);
        test_random_traffic(400);
        wait_drain();

        $display("%0d items in, %0d results checked (append %0d, ordered %0d, pop %0d, query %0d)",
                 items_sent, results_seen, op_count[OP_APPEND], op_count[OP_ORDERED],
                 op_count[OP_POP], op_count[OP_QUERY]);
        $display("refused on full %0d, on empty %0d, peak occupancy %0d, both compare modes",
                 refused_full, refused_empty, peak_count);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
